>>> rtl/krmt_pkg.sv
// ----------------------------------------------------------------------------
// krmt_pkg
// Shared types and constants of the keyed record and marker table: command
// codes and the layout of one stored record (cause and four payload words).
// ----------------------------------------------------------------------------
package krmt_pkg;

    typedef enum logic [2:0] {
        CMD_RECORD    = 3'd0,
        CMD_GET       = 3'd1,
        CMD_MARK      = 3'd2,
        CMD_IS_MARKED = 3'd3,
        CMD_FORGET    = 3'd4
    } t_cmd;

    localparam int CAUSE_W = 8;
    localparam int WORD_W  = 32;
    localparam int INKEY_W = 32;
    // cause, damage, push x, push y, push z from the top bit down
    localparam int DATA_W  = CAUSE_W + 4 * WORD_W;

endpackage

>>> rtl/krmt_ram.sv
// ----------------------------------------------------------------------------
// krmt_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. A read sees data written at earlier edges.
// ----------------------------------------------------------------------------
module krmt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/keyed_record_and_marker_table_core.sv
// ----------------------------------------------------------------------------
// keyed_record_and_marker_table_core
// Fully associative record table and marker set, SLOTS entries each, keyed
// by a nonzero key, with one item and one result per command.
// ----------------------------------------------------------------------------
// Usage: after reset the block runs a clearing pass over every slot of the
// key memory and holds o_stall high meanwhile. Each item with a nonzero key
// and a known command then scans every slot in ascending order through the
// one read port of the key memory, one slot a cycle; a found get hit then
// reads the record memory as well. Items with key zero or an unknown
// command skip the scan and return all zeros. One item is in work at a
// time; a finished result waits in the output register while the next
// item is accepted.
// ----------------------------------------------------------------------------
module keyed_record_and_marker_table_core #(
    parameter int SLOTS    = 256,
    parameter int KEY_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_command,
    input  logic [31:0] i_key,
    input  logic [7:0]  i_cause,
    input  logic [31:0] i_damage_word,
    input  logic [31:0] i_push_x_word,
    input  logic [31:0] i_push_y_word,
    input  logic [31:0] i_push_z_word,

    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_found,
    output logic [7:0]  o_cause_out,
    output logic [31:0] o_damage_out,
    output logic [31:0] o_push_x_out,
    output logic [31:0] o_push_y_out,
    output logic [31:0] o_push_z_out
);

    localparam int KW = (KEY_BITS < krmt_pkg::INKEY_W) ? KEY_BITS : krmt_pkg::INKEY_W;
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DW = krmt_pkg::DATA_W;
    localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FIN,
        S_DWAIT,
        S_OUT
    } t_state;

    t_state          r_state;
    krmt_pkg::t_cmd  r_cmd;
    logic [KW-1:0]   r_key;
    logic [DW-1:0]   r_in_data;
    logic [AW-1:0]   r_addr;
    logic            r_issue_done;
    logic            r_rd_vld;
    logic [AW-1:0]   r_rd_idx;
    logic            r_hit;
    logic [AW-1:0]   r_hit_slot;
    logic [KW-1:0]   r_hit_oth;
    logic            r_have;
    logic [AW-1:0]   r_emp_slot;
    logic [KW-1:0]   r_emp_oth;
    logic            r_p_found;
    logic [DW-1:0]   r_p_data;
    logic            r_ovalid;
    logic            r_ofound;
    logic [DW-1:0]   r_odata;

    // key memory word: marker key above, record key below
    logic            key_we;
    logic [AW-1:0]   key_waddr;
    logic [2*KW-1:0] key_wdata;
    logic [2*KW-1:0] key_rdata;
    logic            dat_we;
    logic [AW-1:0]   dat_waddr;
    logic [DW-1:0]   dat_rdata;

    logic [KW-1:0]   rd_r;
    logic [KW-1:0]   rd_m;
    logic            m_rec;
    logic            m_mrk;
    logic            e_rec;
    logic            e_mrk;
    logic            hit_now;
    logic            emp_now;
    logic [KW-1:0]   oth_now;
    logic [KW-1:0]   in_key;
    logic            cmd_known;

    krmt_ram #(
        .WIDTH (2 * KW),
        .DEPTH (SLOTS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (key_wdata),
        .i_raddr (r_addr),
        .o_rdata (key_rdata)
    );

    krmt_ram #(
        .WIDTH (DW),
        .DEPTH (SLOTS)
    ) u_dat_ram (
        .i_clk   (i_clk),
        .i_we    (dat_we),
        .i_waddr (dat_waddr),
        .i_wdata (r_in_data),
        .i_raddr (r_hit_slot),
        .o_rdata (dat_rdata)
    );

    assign in_key    = i_key[KW-1:0];
    assign cmd_known = (i_command <= krmt_pkg::CMD_FORGET);

    assign rd_r  = key_rdata[KW-1:0];
    assign rd_m  = key_rdata[2*KW-1:KW];
    assign m_rec = r_rd_vld && (rd_r == r_key);
    assign m_mrk = r_rd_vld && (rd_m == r_key);
    assign e_rec = r_rd_vld && (rd_r == '0);
    assign e_mrk = r_rd_vld && (rd_m == '0);

    always_comb begin
        case (r_cmd)
            krmt_pkg::CMD_RECORD, krmt_pkg::CMD_GET: begin
                hit_now = m_rec;
                emp_now = e_rec;
                oth_now = rd_m;
            end
            default: begin
                hit_now = m_mrk;
                emp_now = e_mrk;
                oth_now = rd_r;
            end
        endcase
    end

    always_comb begin
        key_we    = 1'b0;
        key_waddr = r_rd_idx;
        key_wdata = '0;
        dat_we    = 1'b0;
        dat_waddr = r_hit ? r_hit_slot : r_emp_slot;
        case (r_state)
            S_CLEAR: begin
                key_we    = 1'b1;
                key_waddr = r_addr;
            end
            S_SCAN: begin
                // drop the key from whichever half holds it
                if (r_cmd == krmt_pkg::CMD_FORGET && (m_rec || m_mrk)) begin
                    key_we    = 1'b1;
                    key_wdata = {(m_mrk ? {KW{1'b0}} : rd_m), (m_rec ? {KW{1'b0}} : rd_r)};
                end
            end
            S_FIN: begin
                case (r_cmd)
                    krmt_pkg::CMD_RECORD: begin
                        key_we    = r_hit || r_have;
                        key_waddr = r_hit ? r_hit_slot : r_emp_slot;
                        key_wdata = {(r_hit ? r_hit_oth : r_emp_oth), r_key};
                        dat_we    = r_hit || r_have;
                    end
                    krmt_pkg::CMD_MARK: begin
                        key_we    = !r_hit && r_have;
                        key_waddr = r_emp_slot;
                        key_wdata = {r_key, r_emp_oth};
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == S_SCAN) && !r_issue_done;
            r_rd_idx <= r_addr;
            // S_OUT reloads the output register itself
            if (r_ovalid && !i_stall && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    if (r_addr == LAST) begin
                        r_addr  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd        <= krmt_pkg::t_cmd'(i_command);
                        r_key        <= in_key;
                        r_in_data    <= {i_cause, i_damage_word, i_push_x_word,
                                         i_push_y_word, i_push_z_word};
                        r_addr       <= '0;
                        r_issue_done <= 1'b0;
                        r_hit        <= 1'b0;
                        r_have       <= 1'b0;
                        r_p_found    <= 1'b0;
                        r_p_data     <= '0;
                        if (in_key == '0 || !cmd_known) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (!r_issue_done) begin
                        if (r_addr == LAST) begin
                            r_issue_done <= 1'b1;
                        end else begin
                            r_addr <= r_addr + 1'b1;
                        end
                    end
                    // keep the first match and the first empty slot
                    if (hit_now && !r_hit) begin
                        r_hit      <= 1'b1;
                        r_hit_slot <= r_rd_idx;
                        r_hit_oth  <= oth_now;
                    end
                    if (emp_now && !r_have) begin
                        r_have     <= 1'b1;
                        r_emp_slot <= r_rd_idx;
                        r_emp_oth  <= oth_now;
                    end
                    if (r_rd_vld && r_rd_idx == LAST) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_addr  <= '0;
                    r_state <= (r_cmd == krmt_pkg::CMD_GET && r_hit) ? S_DWAIT : S_OUT;
                    case (r_cmd)
                        krmt_pkg::CMD_RECORD: begin
                            r_p_found <= r_hit || r_have;
                        end
                        krmt_pkg::CMD_GET: begin
                            r_p_found <= r_hit;
                        end
                        krmt_pkg::CMD_MARK: begin
                            r_p_found <= !r_hit && r_have;
                        end
                        krmt_pkg::CMD_IS_MARKED: begin
                            r_p_found <= r_hit;
                        end
                        default: begin
                            r_p_found <= 1'b0;
                        end
                    endcase
                end
                S_DWAIT: begin
                    r_p_data <= dat_rdata;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    // hold the result until the output register is free
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid <= 1'b1;
                        r_ofound <= r_p_found;
                        r_odata  <= r_p_data;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_found      = r_ofound;
    assign o_cause_out  = r_odata[DW-1 -: krmt_pkg::CAUSE_W];
    assign o_damage_out = r_odata[4*krmt_pkg::WORD_W-1 -: krmt_pkg::WORD_W];
    assign o_push_x_out = r_odata[3*krmt_pkg::WORD_W-1 -: krmt_pkg::WORD_W];
    assign o_push_y_out = r_odata[2*krmt_pkg::WORD_W-1 -: krmt_pkg::WORD_W];
    assign o_push_z_out = r_odata[krmt_pkg::WORD_W-1:0];

endmodule

>>> test/keyed_record_and_marker_table_core_tb.sv
// ----------------------------------------------------------------------------
// keyed_record_and_marker_table_core_tb
// Self-checking bench for the keyed record and marker table. A short table of
// directed items covers empty tables, extreme keys and payloads, key zero,
// spare commands, duplicate marks and forget. Random traffic follows: a small
// key pool, then a pass that fills both tables to the brim, then mixed traffic
// on a full table with forgets and new keys. Every result is checked against
// a table predictor kept in the bench, and both sides idle at random.
// ----------------------------------------------------------------------------
module keyed_record_and_marker_table_core_tb;

    localparam int SLOTS          = 256;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int POOL_SIZE      = 12;
    localparam logic [31:0] FILL_TAG = 32'hC300_0000;

    localparam logic [2:0] CMD_SPARE_5 = 3'd5;
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    typedef enum logic [1:0] {
        WANT_MODEL,
        WANT_ZERO,
        WANT_FOUND,
        WANT_ECHO
    } t_want;

    typedef struct packed {
        logic        found;
        logic [7:0]  cause;
        logic [31:0] damage;
        logic [31:0] push_x;
        logic [31:0] push_y;
        logic [31:0] push_z;
    } t_result;

    typedef struct packed {
        t_want       want;
        logic [2:0]  cmd;
        logic [31:0] key;
        logic [7:0]  cause;
        logic [31:0] damage;
        logic [31:0] push_x;
        logic [31:0] push_y;
        logic [31:0] push_z;
    } t_item;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_command;
    logic [31:0] i_key;
    logic [7:0]  i_cause;
    logic [31:0] i_damage_word;
    logic [31:0] i_push_x_word;
    logic [31:0] i_push_y_word;
    logic [31:0] i_push_z_word;
    logic        o_valid;
    logic        i_stall;
    logic        o_found;
    logic [7:0]  o_cause_out;
    logic [31:0] o_damage_out;
    logic [31:0] o_push_x_out;
    logic [31:0] o_push_y_out;
    logic [31:0] o_push_z_out;

    // predicted table contents
    logic [31:0] rec_key    [SLOTS];
    logic [7:0]  rec_cause  [SLOTS];
    logic [31:0] rec_damage [SLOTS];
    logic [31:0] rec_push_x [SLOTS];
    logic [31:0] rec_push_y [SLOTS];
    logic [31:0] rec_push_z [SLOTS];
    logic [31:0] mark_key   [SLOTS];

    t_result     pending_results [$];
    t_item       directed_rows [$];
    logic [31:0] key_pool [POOL_SIZE];
    int          mismatch_cnt;
    int          idle_cycles;
    bit          calm;

    keyed_record_and_marker_table_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_key         (i_key),
        .i_cause       (i_cause),
        .i_damage_word (i_damage_word),
        .i_push_x_word (i_push_x_word),
        .i_push_y_word (i_push_y_word),
        .i_push_z_word (i_push_z_word),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_found       (o_found),
        .o_cause_out   (o_cause_out),
        .o_damage_out  (o_damage_out),
        .o_push_x_out  (o_push_x_out),
        .o_push_y_out  (o_push_y_out),
        .o_push_z_out  (o_push_z_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // mostly short, now and then very long
    function automatic int burst_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 4);
        if (r < 97) return $urandom_range(5, 40);
        return $urandom_range(100, 400);
    endfunction

    function automatic t_item make_item(t_want want, logic [2:0] cmd, logic [31:0] key,
                                        logic [7:0] cause, logic [31:0] damage,
                                        logic [31:0] push_x, logic [31:0] push_y,
                                        logic [31:0] push_z);
        t_item it;
        it.want   = want;
        it.cmd    = cmd;
        it.key    = key;
        it.cause  = cause;
        it.damage = damage;
        it.push_x = push_x;
        it.push_y = push_y;
        it.push_z = push_z;
        return it;
    endfunction

    function automatic void add_row(t_want want, logic [2:0] cmd, logic [31:0] key,
                                    logic [7:0] cause, logic [31:0] damage,
                                    logic [31:0] push_x, logic [31:0] push_y,
                                    logic [31:0] push_z);
        directed_rows.push_back(make_item(want, cmd, key, cause, damage,
                                          push_x, push_y, push_z));
    endfunction

    function automatic int used_slots(bit markers);
        int n;
        n = 0;
        for (int s = 0; s < SLOTS; s++) begin
            if ((markers ? mark_key[s] : rec_key[s]) != '0) n++;
        end
        return n;
    endfunction

    // advance the predicted tables by one item and work out its result
    function automatic t_result apply_table_op(t_item it);
        t_result res;
        int      slot;
        bit      have;
        bit      hit;
        res  = '0;
        slot = 0;
        have = 1'b0;
        hit  = 1'b0;
        if (it.key == '0) return res;
        case (it.cmd)
            krmt_pkg::CMD_RECORD: begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (rec_key[s] == it.key) begin
                        slot = s;
                        have = 1'b1;
                        break;
                    end
                    if (!have && rec_key[s] == '0) begin
                        slot = s;
                        have = 1'b1;
                    end
                end
                if (have) begin
                    rec_key[slot]    = it.key;
                    rec_cause[slot]  = it.cause;
                    rec_damage[slot] = it.damage;
                    rec_push_x[slot] = it.push_x;
                    rec_push_y[slot] = it.push_y;
                    rec_push_z[slot] = it.push_z;
                    res.found        = 1'b1;
                end
            end
            krmt_pkg::CMD_GET: begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (rec_key[s] == it.key) begin
                        res = {1'b1, rec_cause[s], rec_damage[s], rec_push_x[s],
                               rec_push_y[s], rec_push_z[s]};
                        break;
                    end
                end
            end
            krmt_pkg::CMD_MARK: begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (mark_key[s] == it.key) begin
                        hit = 1'b1;
                        break;
                    end
                    if (!have && mark_key[s] == '0) begin
                        slot = s;
                        have = 1'b1;
                    end
                end
                if (!hit && have) begin
                    mark_key[slot] = it.key;
                    res.found      = 1'b1;
                end
            end
            krmt_pkg::CMD_IS_MARKED: begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (mark_key[s] == it.key) begin
                        res.found = 1'b1;
                        break;
                    end
                end
            end
            krmt_pkg::CMD_FORGET: begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (mark_key[s] == it.key) mark_key[s] = '0;
                    if (rec_key[s] == it.key) rec_key[s] = '0;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic push_item(t_item it);
        t_result res;
        int      gap;
        gap = calm ? 0 : burst_len();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_command     <= it.cmd;
        i_key         <= it.key;
        i_cause       <= it.cause;
        i_damage_word <= it.damage;
        i_push_x_word <= it.push_x;
        i_push_y_word <= it.push_y;
        i_push_z_word <= it.push_z;
        i_valid       <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        res = apply_table_op(it);
        case (it.want)
            WANT_ZERO:  res = '0;
            WANT_FOUND: res = {1'b1, 8'h00, 32'h0, 32'h0, 32'h0, 32'h0};
            // a get row carries the stored values it should read back
            WANT_ECHO:  res = {1'b1, it.cause, it.damage, it.push_x, it.push_y, it.push_z};
            default: ;
        endcase
        pending_results.push_back(res);
    endtask

    function automatic logic [2:0] pick_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return krmt_pkg::CMD_RECORD;
        if (r < 52) return krmt_pkg::CMD_GET;
        if (r < 67) return krmt_pkg::CMD_MARK;
        if (r < 82) return krmt_pkg::CMD_IS_MARKED;
        if (r < 94) return krmt_pkg::CMD_FORGET;
        return 3'($urandom_range(CMD_SPARE_5, CMD_SPARE_7));
    endfunction

    // fill_span > 0 lets keys come from the fill pass too
    function automatic logic [31:0] pick_key(int fill_span);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 15) return $urandom;
        if (fill_span > 0 && r < 55) return FILL_TAG | $urandom_range(0, fill_span - 1);
        if (fill_span > 0 && r < 65) return FILL_TAG | (fill_span + $urandom_range(0, 40));
        return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    function automatic t_item random_item(logic [2:0] cmd, logic [31:0] key);
        return make_item(WANT_MODEL, cmd, key, 8'($urandom_range(0, 255)),
                         $urandom, $urandom, $urandom, $urandom);
    endfunction

    function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v) begin
            mismatch_cnt++;
            $display("%0t: %s expected %h got %h", $time, name, want_v, got_v);
        end
    endfunction

    // result checking and watchdog
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: result with no item pending, expected none got found=%b",
                             $time, o_found);
                end else begin
                    want = pending_results.pop_front();
                    check_field("found", 32'(want.found), 32'(o_found));
                    check_field("cause_out", 32'(want.cause), 32'(o_cause_out));
                    check_field("damage_out", want.damage, o_damage_out);
                    check_field("push_x_out", want.push_x, o_push_x_out);
                    check_field("push_y_out", want.push_y, o_push_y_out);
                    check_field("push_z_out", want.push_z, o_push_z_out);
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // receiver stalls
    initial begin : stall_gen
        int hold;
        int n;
        hold    = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
            end else begin
                n = calm ? 0 : burst_len();
                if (n > 0) begin
                    i_stall <= 1'b1;
                    hold = n - 1;
                end else begin
                    i_stall <= 1'b0;
                    hold = calm ? 0 : $urandom_range(0, 6);
                end
            end
        end
    end

    initial begin : stimulus
        logic [31:0] fill_key;
        int          fill_n;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_command     = krmt_pkg::CMD_RECORD;
        i_key         = '0;
        i_cause       = '0;
        i_damage_word = '0;
        i_push_x_word = '0;
        i_push_y_word = '0;
        i_push_z_word = '0;
        mismatch_cnt  = 0;
        idle_cycles   = 0;
        calm          = 1'b0;
        fill_n        = 0;
        for (int s = 0; s < SLOTS; s++) begin
            rec_key[s]  = '0;
            mark_key[s] = '0;
        end
        key_pool[0] = 32'h0000_0001;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h8000_0000;
        for (int k = 3; k < POOL_SIZE; k++) key_pool[k] = $urandom | 32'h1;

        add_row(WANT_ZERO,  krmt_pkg::CMD_GET,       32'h5, 8'h00,
                32'h0, 32'h0, 32'h0, 32'h0);
        add_row(WANT_ZERO,  krmt_pkg::CMD_IS_MARKED, 32'h5, 8'h00,
                32'h0, 32'h0, 32'h0, 32'h0);
        add_row(WANT_ZERO,  krmt_pkg::CMD_RECORD,    32'h0, 8'hFF, '1, '1, '1, '1);
        add_row(WANT_FOUND, krmt_pkg::CMD_RECORD,    32'hFFFF_FFFF, 8'hFF, '1, '1, '1, '1);
        add_row(WANT_ECHO,  krmt_pkg::CMD_GET,       32'hFFFF_FFFF, 8'hFF, '1, '1, '1, '1);
        add_row(WANT_FOUND, krmt_pkg::CMD_RECORD,    32'h1, 8'h00,
                32'h0, 32'h0, 32'h0, 32'h0);
        add_row(WANT_ECHO,  krmt_pkg::CMD_GET,       32'h1, 8'h00,
                32'h0, 32'h0, 32'h0, 32'h0);
        add_row(WANT_FOUND, krmt_pkg::CMD_MARK,      32'h1, 8'h00,
                32'h0, 32'h0, 32'h0, 32'h0);
        add_row(WANT_ZERO,  krmt_pkg::CMD_MARK,      32'h1, 8'h00,
                32'h0, 32'h0, 32'h0, 32'h0);
        add_row(WANT_FOUND, krmt_pkg::CMD_IS_MARKED, 32'h1, 8'h00,
                32'h0, 32'h0, 32'h0, 32'h0);
        add_row(WANT_ZERO,  krmt_pkg::CMD_MARK,      32'h0, 8'h00,
                32'h0, 32'h0, 32'h0, 32'h0);
        add_row(WANT_ZERO,  krmt_pkg::CMD_IS_MARKED, 32'h0, 8'h00,
                32'h0, 32'h0, 32'h0, 32'h0);
        add_row(WANT_ZERO,  krmt_pkg::CMD_FORGET,    32'hFFFF_FFFF, 8'h00,
                32'h0, 32'h0, 32'h0, 32'h0);
        add_row(WANT_ZERO,  krmt_pkg::CMD_GET,       32'hFFFF_FFFF, 8'h00,
                32'h0, 32'h0, 32'h0, 32'h0);
        // slot 0 is empty again, so this must update the match further on
        add_row(WANT_FOUND, krmt_pkg::CMD_RECORD,    32'h1, 8'h5A,
                32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
        add_row(WANT_ECHO,  krmt_pkg::CMD_GET,       32'h1, 8'h5A,
                32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
        add_row(WANT_MODEL, krmt_pkg::CMD_RECORD,    32'h2, 8'hC3,
                32'hA5A5_5A5A, 32'h0000_FFFF, 32'hFFFF_0000, 32'h8000_0001);
        add_row(WANT_MODEL, krmt_pkg::CMD_GET,       32'h2, 8'h00,
                32'h0, 32'h0, 32'h0, 32'h0);
        add_row(WANT_ZERO,  CMD_SPARE_5,             32'h1, 8'hFF, '1, '1, '1, '1);
        add_row(WANT_ZERO,  CMD_SPARE_7,             32'h2, 8'hFF, '1, '1, '1, '1);
        add_row(WANT_ZERO,  CMD_SPARE_6,             32'h1, 8'h00,
                32'h0, 32'h0, 32'h0, 32'h0);
        add_row(WANT_ZERO,  krmt_pkg::CMD_FORGET,    32'h1, 8'h00,
                32'h0, 32'h0, 32'h0, 32'h0);
        add_row(WANT_ZERO,  krmt_pkg::CMD_IS_MARKED, 32'h1, 8'h00,
                32'h0, 32'h0, 32'h0, 32'h0);
        add_row(WANT_ZERO,  krmt_pkg::CMD_GET,       32'h1, 8'h00,
                32'h0, 32'h0, 32'h0, 32'h0);
        add_row(WANT_MODEL, krmt_pkg::CMD_GET,       32'h2, 8'h00,
                32'h0, 32'h0, 32'h0, 32'h0);

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) push_item(directed_rows[r]);

        // small key pool, the first stretch without idling
        for (int n = 0; n < 130; n++) begin
            calm = (n < 40);
            push_item(random_item(pick_cmd(), pick_key(0)));
        end

        // fill both tables to the last slot, with read-backs along the way
        while (used_slots(1'b0) < SLOTS || used_slots(1'b1) < SLOTS) begin
            calm     = (fill_n < 100);
            fill_key = FILL_TAG | fill_n;
            if (used_slots(1'b0) < SLOTS)
                push_item(random_item(krmt_pkg::CMD_RECORD, fill_key));
            if (used_slots(1'b1) < SLOTS)
                push_item(random_item(krmt_pkg::CMD_MARK, fill_key));
            if (fill_n % 8 == 7)
                push_item(random_item(krmt_pkg::CMD_GET,
                                      FILL_TAG | $urandom_range(0, fill_n)));
            fill_n++;
        end
        calm = 1'b0;

        // full tables: drops, updates, forgets and refills
        for (int n = 0; n < 120; n++) push_item(random_item(pick_cmd(), pick_key(fill_n)));

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SLOTS + 8) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/krmt_pkg.sv
rtl/krmt_ram.sv
rtl/keyed_record_and_marker_table_core.sv
test/keyed_record_and_marker_table_core_tb.sv
